// ===== hw/rtl/srtps_pkg.sv =====
`timescale 1ns / 1ps

package srtps_pkg;

  // Job table geometry
  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = $clog2(SLOTS + 1);

  // Field widths
  localparam int ID_W   = 8;
  localparam int REM_W  = 16;
  localparam int TIME_W = 32;

  // Stream payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Opcode carried on the input tuser
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // One job table entry as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   job;
    logic [REM_W-1:0]  rem;
    logic [TIME_W-1:0] arr;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/srt_preemptive_scheduler_unit.sv =====
`timescale 1ns / 1ps

// Preemptive shortest-remaining-time scheduler over a table of job slots.
// Input stream: tuser is the opcode (arrive or tick), tdata holds job id and
// burst. An arrive beat with a nonzero burst stores the job in the lowest free
// slot (if any), stamped with the current time; a tick runs the best ready
// job for one time unit. Output stream: exactly one result beat per input beat.
// Job entries live in a synchronous memory with one write and one registered
// read port; a tick sweeps it one slot per cycle to find the job with the least
// remaining time (ties to the lower id, then the lower slot).
// An arrive goes from the accepting edge to the emit state, which loads the
// result register; a tick first sweeps the slots, then decides and updates
// before its emit. When the tick's job finishes, another sweep picks the next
// job before a new beat is taken. The emit state waits while the result
// register still holds an untaken beat.
// One beat is in work at a time. The result register frees the input side
// once its beat is loaded, so a stalled receiver only holds back the result
// of the following beat.
// Reset empties the table (valid bits only), marks no job running and
// clears the time counter; it needs no memory sweep.
module srt_preemptive_scheduler_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] job_id, [23:8] burst
  input  logic [srtps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] op
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] accepted, [1] running_valid, [9:2] running_id, [10] done_res,
  // [18:11] done_id, [50:19] turnaround, [55:51] zero
  output logic [srtps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int IDX_W  = srtps_pkg::IDX_W;
  localparam int SLOT_W = srtps_pkg::SLOT_W;
  localparam int ID_W   = srtps_pkg::ID_W;
  localparam int REM_W  = srtps_pkg::REM_W;
  localparam int TIME_W = srtps_pkg::TIME_W;
  localparam logic [SLOT_W-1:0] IDLE_MARK = SLOT_W'(srtps_pkg::SLOTS);

  srtps_pkg::state_t state, state_next;

  // Control state
  logic [srtps_pkg::SLOTS-1:0] slot_valid;
  logic [SLOT_W-1:0]           active_slot;
  logic [TIME_W-1:0]           now_time;
  logic [SLOT_W-1:0]           scan_cnt;
  logic                        rd_vld;
  logic                        rescan;

  // Sweep and datapath registers
  logic [IDX_W-1:0]  rd_idx;
  logic              best_found;
  logic [IDX_W-1:0]  best_idx;
  logic [ID_W-1:0]   best_job;
  logic [REM_W-1:0]  best_rem;
  logic [TIME_W-1:0] best_arr;
  logic [ID_W-1:0]   act_job;
  logic [REM_W-1:0]  act_rem;
  logic [TIME_W-1:0] act_arr;
  logic              ch_run;
  logic [IDX_W-1:0]  ch_idx;
  logic [ID_W-1:0]   ch_job;
  logic [REM_W-1:0]  ch_rem;
  logic [TIME_W-1:0] ch_arr;
  logic              res_accepted;
  logic              res_run;
  logic [ID_W-1:0]   res_run_id;
  logic              res_done;
  logic [ID_W-1:0]   res_done_id;

  // Slot memory
  srtps_pkg::entry_t slot_mem [srtps_pkg::SLOTS];
  srtps_pkg::entry_t rd_data;
  srtps_pkg::entry_t mem_wdata;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  rd_addr;

  // Input fields
  logic              in_op;
  logic [ID_W-1:0]   in_job;
  logic [REM_W-1:0]  in_burst;
  logic              in_beat;

  assign in_op    = s_axis_tuser;
  assign in_job   = s_axis_tdata[7:0];
  assign in_burst = s_axis_tdata[23:8];
  assign in_beat  = s_axis_tvalid && s_axis_tready;

  // Lowest free slot
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic             store_ok;

  always_comb begin
    free_idx = '0;
    for (int i = srtps_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign free_any = ~&slot_valid;
  assign store_ok = free_any && (in_burst != '0);

  // Running job still holds its slot
  logic             act_live;
  logic [IDX_W-1:0] act_idx;

  assign act_idx  = active_slot[IDX_W-1:0];
  assign act_live = (active_slot < IDLE_MARK) && slot_valid[act_idx];

  // Sweep candidate against the best so far
  logic scan_issue;
  logic scan_end;
  logic cand_live;
  logic cand_better;
  logic cand_is_act;

  assign scan_issue  = scan_cnt < IDLE_MARK;
  assign scan_end    = scan_cnt == IDLE_MARK;
  assign cand_live   = rd_vld && slot_valid[rd_idx];
  assign cand_better = !best_found || (rd_data.rem < best_rem) ||
                       ((rd_data.rem == best_rem) && (rd_data.job < best_job));
  assign cand_is_act = (active_slot < IDLE_MARK) && (rd_idx == act_idx);

  // Tick decision: keep the running job unless strictly beaten
  logic take_best;

  assign take_best = best_found && (!act_live || (best_rem < act_rem));

  logic out_free;
  logic done_now;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign done_now = ch_run && (ch_rem == REM_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      srtps_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_next = (in_op == srtps_pkg::OP_TICK) ? srtps_pkg::ST_SCAN
                                                     : srtps_pkg::ST_EMIT;
        end
      end
      srtps_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = srtps_pkg::ST_DECIDE;
        end
      end
      srtps_pkg::ST_DECIDE: begin
        state_next = rescan ? srtps_pkg::ST_IDLE : srtps_pkg::ST_UPDATE;
      end
      srtps_pkg::ST_UPDATE: begin
        state_next = srtps_pkg::ST_EMIT;
      end
      srtps_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = res_done ? srtps_pkg::ST_SCAN : srtps_pkg::ST_IDLE;
        end
      end
      default: state_next = srtps_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and memory port
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = free_idx;
    mem_wdata     = '{job: in_job, rem: in_burst, arr: now_time};
    rd_addr       = scan_cnt[IDX_W-1:0];
    unique case (state)
      srtps_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        mem_we        = in_beat && (in_op == srtps_pkg::OP_ARRIVE) && store_ok;
      end
      srtps_pkg::ST_UPDATE: begin
        mem_we    = ch_run;
        mem_waddr = ch_idx;
        mem_wdata = '{job: ch_job, rem: ch_rem - REM_W'(1), arr: ch_arr};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Slot memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= slot_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srtps_pkg::ST_IDLE;
      slot_valid    <= '0;
      active_slot   <= IDLE_MARK;
      now_time      <= '0;
      scan_cnt      <= '0;
      rd_vld        <= 1'b0;
      rescan        <= 1'b0;
      best_found    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      // Result register: load on emit, clear once taken
      if ((state == srtps_pkg::ST_EMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        srtps_pkg::ST_IDLE: begin
          if (in_beat) begin
            scan_cnt   <= '0;
            rd_vld     <= 1'b0;
            rescan     <= 1'b0;
            best_found <= 1'b0;
            if ((in_op == srtps_pkg::OP_ARRIVE) && store_ok) begin
              slot_valid[free_idx] <= 1'b1;
            end
          end
        end
        srtps_pkg::ST_SCAN: begin
          rd_vld <= scan_issue;
          if (scan_issue) begin
            scan_cnt <= scan_cnt + SLOT_W'(1);
          end
          if (cand_live && cand_better) begin
            best_found <= 1'b1;
          end
        end
        srtps_pkg::ST_DECIDE: begin
          if (rescan) begin
            active_slot <= best_found ? SLOT_W'(best_idx) : IDLE_MARK;
          end else if (take_best) begin
            active_slot <= SLOT_W'(best_idx);
          end else if (!act_live) begin
            active_slot <= IDLE_MARK;
          end
        end
        srtps_pkg::ST_UPDATE: begin
          if (now_time != srtps_pkg::TIME_MAX) begin
            now_time <= now_time + TIME_W'(1);
          end
          if (done_now) begin
            slot_valid[ch_idx] <= 1'b0;
          end
        end
        srtps_pkg::ST_EMIT: begin
          if (out_free) begin
            scan_cnt      <= '0;
            rd_vld        <= 1'b0;
            rescan        <= 1'b1;
            best_found    <= 1'b0;
          end
        end
        default: begin
          rd_vld <= 1'b0;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      srtps_pkg::ST_IDLE: begin
        res_accepted <= store_ok;
        res_run      <= 1'b0;
        res_run_id   <= '0;
        res_done     <= 1'b0;
        res_done_id  <= '0;
      end
      srtps_pkg::ST_SCAN: begin
        rd_idx <= rd_addr;
        if (cand_live && cand_better) begin
          best_idx <= rd_idx;
          best_job <= rd_data.job;
          best_rem <= rd_data.rem;
          best_arr <= rd_data.arr;
        end
        if (rd_vld && cand_is_act) begin
          act_job <= rd_data.job;
          act_rem <= rd_data.rem;
          act_arr <= rd_data.arr;
        end
      end
      srtps_pkg::ST_DECIDE: begin
        ch_run <= take_best || act_live;
        ch_idx <= take_best ? best_idx : act_idx;
        ch_job <= take_best ? best_job : act_job;
        ch_rem <= take_best ? best_rem : act_rem;
        ch_arr <= take_best ? best_arr : act_arr;
      end
      srtps_pkg::ST_UPDATE: begin
        res_accepted <= 1'b0;
        res_run      <= ch_run;
        res_run_id   <= ch_run ? ch_job : '0;
        res_done     <= done_now;
        res_done_id  <= done_now ? ch_job : '0;
      end
      srtps_pkg::ST_EMIT: begin
        if (out_free) begin
          m_axis_tdata <= {5'd0,
                           res_done ? (now_time - ch_arr) : TIME_W'(0),
                           res_done_id, res_done, res_run_id, res_run,
                           res_accepted};
        end
      end
      default: begin
        ch_run <= 1'b0;
      end
    endcase
  end

  // Running job always holds a live slot between beats
  a_active_live: assert property (@(posedge clk) disable iff (rst)
    (state == srtps_pkg::ST_IDLE && active_slot < IDLE_MARK) |-> slot_valid[act_idx])
    else $error("running job points at a free slot");

  // A finishing job frees exactly one slot
  a_free_one: assert property (@(posedge clk) disable iff (rst)
    (state == srtps_pkg::ST_UPDATE && done_now) |=>
      ($countones(slot_valid) == $countones($past(slot_valid)) - 1))
    else $error("finish did not free one slot");

  // Time never runs backward
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (now_time >= $past(now_time)))
    else $error("time counter went backward");

  // Arrive and tick results never mix; a finish implies a run
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!(m_axis_tdata[0] && m_axis_tdata[1]) &&
                       (!m_axis_tdata[10] || m_axis_tdata[1])))
    else $error("inconsistent result flags");

  // No memory write during a sweep
  a_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == srtps_pkg::ST_SCAN) |-> !mem_we)
    else $error("slot memory written during sweep");

endmodule
